// File: rtl/core/dck_pkg.sv
package dck_pkg;

    localparam int DEF_MAX_PROCESSES = 16;
    localparam int DEF_MAX_RESOURCES = 16;
    localparam int DEF_AMOUNT_BITS   = 16;

    // a run never reports more processes than this
    localparam int RESULT_LIMIT = 16;

    localparam int CFG_BITS     = 5;
    localparam int CFG_IDX_BITS = 1;
    localparam int IDX_BITS     = 4;
    localparam int AMT_IN_BITS  = 16;
    localparam int PID_BITS     = 4;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(1);

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_REQUEST = 2'd1,
        REQ_AVAIL   = 2'd2,
        REQ_RUN     = 2'd3
    } t_req;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PROCESS_COUNT  = 1'b0,
        REG_RESOURCE_COUNT = 1'b1
    } t_reg;

    typedef struct packed {
        t_req                   op;
        logic [IDX_BITS-1:0]    proc;
        logic [IDX_BITS-1:0]    res;
        logic [AMT_IN_BITS-1:0] amt;
    } t_cmd;

    // counts already clipped to what the engine supports
    typedef struct packed {
        logic [CFG_BITS-1:0] proc_n;
        logic [CFG_BITS-1:0] res_m;
    } t_cfg;

endpackage

// File: rtl/core/dck_front.sv
module dck_front import dck_pkg::*; #(
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = DEF_MAX_RESOURCES
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic [IDX_BITS-1:0]     i_process_index,
    input  logic [IDX_BITS-1:0]     i_resource_index,
    input  logic [AMT_IN_BITS-1:0]  i_amount,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    input  logic                    i_full,
    output logic                    o_push,
    output t_cmd                    o_cmd,
    output t_cfg                    o_cfg
);

    localparam int NP = (MAX_PROCESSES < RESULT_LIMIT) ? MAX_PROCESSES : RESULT_LIMIT;

    logic [CFG_BITS-1:0] r_proc_cnt;
    logic [CFG_BITS-1:0] r_res_cnt;
    logic                w_accept;
    logic                w_keep;
    logic                w_proc_ok;
    logic                w_res_ok;
    t_req                w_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proc_cnt <= CFG_RESET;
            r_res_cnt  <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_index))
                REG_PROCESS_COUNT:  r_proc_cnt <= i_cfg_data;
                REG_RESOURCE_COUNT: r_res_cnt  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        o_cfg.proc_n = (32'(r_proc_cnt) > NP) ? CFG_BITS'(NP) : r_proc_cnt;
        o_cfg.res_m  = (32'(r_res_cnt) > MAX_RESOURCES) ? CFG_BITS'(MAX_RESOURCES) : r_res_cnt;
    end

    assign o_in_ready = !i_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_req      = t_req'(i_req_type);
    assign w_proc_ok  = 32'(i_process_index) < MAX_PROCESSES;
    assign w_res_ok   = 32'(i_resource_index) < MAX_RESOURCES;

    // out of range loads are dropped here and never reach the engine
    always_comb begin
        case (w_req)
            REQ_ALLOC:   w_keep = w_proc_ok && w_res_ok;
            REQ_REQUEST: w_keep = w_proc_ok && w_res_ok;
            REQ_AVAIL:   w_keep = w_res_ok;
            REQ_RUN:     w_keep = 1'b1;
            default:     w_keep = 1'b0;
        endcase
    end

    assign o_push    = w_accept && w_keep;
    assign o_cmd.op   = w_req;
    assign o_cmd.proc = i_process_index;
    assign o_cmd.res  = i_resource_index;
    assign o_cmd.amt  = i_amount;

endmodule

// File: rtl/core/dck_queue.sv
module dck_queue import dck_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    input  logic i_pop,
    output t_cmd o_cmd
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wptr;
    logic [PTR_W-1:0] r_rptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: ;
            endcase
        end
    end

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_slot[r_rptr];

endmodule

// File: rtl/core/dck_back.sv
module dck_back import dck_pkg::*; #(
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
    parameter int AMOUNT_BITS   = DEF_AMOUNT_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_cmd_valid,
    input  t_cmd                i_cmd,
    output logic                o_cmd_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [PID_BITS-1:0] o_process_id,
    output logic                o_deadlocked,
    output logic                o_has_process,
    output logic                o_last
);

    localparam int NP    = (MAX_PROCESSES < RESULT_LIMIT) ? MAX_PROCESSES : RESULT_LIMIT;
    localparam int IW    = (NP > 1) ? $clog2(NP) : 1;
    localparam int MR    = MAX_RESOURCES;
    localparam int JW    = (MR > 1) ? $clog2(MR) : 1;
    localparam int DEPTH = MAX_PROCESSES * MAX_RESOURCES;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(NP + 1);
    localparam int AB    = AMOUNT_BITS;
    // available plus every allocation never wraps
    localparam int WW    = AMOUNT_BITS + CW;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_COPY  = 9'b000000010,
        S_SCAN  = 9'b000000100,
        S_CHECK = 9'b000001000,
        S_ADD   = 9'b000010000,
        S_PEND  = 9'b000100000,
        S_SAFE  = 9'b001000000,
        S_DEAD  = 9'b010000000,
        S_EMPTY = 9'b100000000
    } t_state;

    logic [AB-1:0] m_alloc [DEPTH];
    logic [AB-1:0] m_req   [DEPTH];
    logic [AB-1:0] m_avail [MR];
    logic [WW-1:0] m_work  [MR];

    logic [AB-1:0] r_alloc_q;
    logic [AB-1:0] r_req_q;
    logic [AB-1:0] r_avail_q;
    logic [WW-1:0] r_work_q;

    t_state        r_state;
    logic [IW-1:0] r_i;
    logic [IW-1:0] r_k;
    logic [JW-1:0] r_j;
    logic [JW-1:0] r_pj;
    logic          r_iss;
    logic          r_pv;
    logic          r_plast;
    logic          r_fit;
    logic          r_progress;
    logic [NP-1:0] r_fin;
    logic [CW-1:0] r_total;
    logic [IW-1:0] r_order [NP];

    logic [IW-1:0]       w_i_last;
    logic [JW-1:0]       w_j_last;
    logic [AW-1:0]       w_rd_addr;
    logic [AW-1:0]       w_wr_addr;
    logic [NP-1:0]       w_nmask;
    logic [NP-1:0]       w_unfin;
    logic                w_above;
    logic                w_fail;
    logic                w_out_free;
    logic [WW-1:0]       w_sum;
    logic                w_finish;
    logic                w_next;
    logic                w_emit;
    logic                w_emit_last;
    logic [PID_BITS-1:0] w_emit_pid;
    logic                w_emit_dl;
    logic                w_emit_has;

    assign o_cmd_pop  = (r_state == S_IDLE) && i_cmd_valid;
    assign w_i_last   = IW'(i_cfg.proc_n - 1'b1);
    assign w_j_last   = JW'(i_cfg.res_m - 1'b1);
    assign w_rd_addr  = AW'(32'(r_i) * MR + 32'(r_j));
    assign w_wr_addr  = AW'(32'(i_cmd.proc) * MR + 32'(i_cmd.res));
    assign w_fail     = (WW'(r_req_q) > r_work_q);
    assign w_sum      = r_work_q + WW'(r_alloc_q);
    assign w_out_free = !o_out_valid || i_out_ready;

    always_comb begin
        for (int b = 0; b < NP; b++) begin
            w_nmask[b] = (b < int'(i_cfg.proc_n));
        end
    end

    assign w_unfin = ~r_fin & w_nmask;
    // another deadlocked process further up the index range
    assign w_above = |((w_unfin >> r_k) >> 1);

    always_comb begin
        w_finish = 1'b0;
        w_next   = 1'b0;
        case (r_state)
            S_SCAN: begin
                w_finish = !r_fin[r_i] && (i_cfg.res_m == '0);
                w_next   = r_fin[r_i] || (i_cfg.res_m == '0);
            end
            S_CHECK: begin
                w_finish = r_pv && r_plast && r_fit && !w_fail;
                w_next   = r_pv && r_plast && !(r_fit && !w_fail);
            end
            S_ADD:   w_next = r_pv && r_plast;
            default: ;
        endcase
    end

    always_comb begin
        w_emit      = 1'b0;
        w_emit_last = 1'b0;
        w_emit_pid  = '0;
        w_emit_dl   = 1'b0;
        w_emit_has  = 1'b1;
        case (r_state)
            S_SAFE: begin
                w_emit      = w_out_free;
                w_emit_pid  = PID_BITS'(r_order[r_k]);
                w_emit_last = (r_k == w_i_last);
            end
            S_DEAD: begin
                w_emit      = w_out_free && w_unfin[r_k];
                w_emit_pid  = PID_BITS'(r_k);
                w_emit_dl   = 1'b1;
                w_emit_last = !w_above;
            end
            S_EMPTY: begin
                w_emit      = w_out_free;
                w_emit_has  = 1'b0;
                w_emit_last = 1'b1;
            end
            default: ;
        endcase
    end

    // stores, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.op == REQ_ALLOC) begin
            m_alloc[w_wr_addr] <= AB'(i_cmd.amt);
        end
        r_alloc_q <= m_alloc[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.op == REQ_REQUEST) begin
            m_req[w_wr_addr] <= AB'(i_cmd.amt);
        end
        r_req_q <= m_req[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && i_cmd.op == REQ_AVAIL) begin
            m_avail[JW'(i_cmd.res)] <= AB'(i_cmd.amt);
        end
        r_avail_q <= m_avail[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (r_pv && r_state == S_COPY) begin
            m_work[r_pj] <= WW'(r_avail_q);
        end else if (r_pv && r_state == S_ADD) begin
            m_work[r_pj] <= w_sum;
        end
        r_work_q <= m_work[r_j];
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_order[r_total[IW-1:0]] <= r_i;
        end
        if (w_emit) begin
            o_process_id  <= w_emit_pid;
            o_deadlocked  <= w_emit_dl;
            o_has_process <= w_emit_has;
            o_last        <= w_emit_last;
        end
        if (r_iss) begin
            r_pj    <= r_j;
            r_plast <= (r_j == w_j_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_i         <= '0;
            r_k         <= '0;
            r_j         <= '0;
            r_iss       <= 1'b0;
            r_pv        <= 1'b0;
            r_fit       <= 1'b0;
            r_progress  <= 1'b0;
            r_fin       <= '0;
            r_total     <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_emit) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end

            // element sweep: address out, data back in the following cycle
            if (r_iss) begin
                r_pv <= 1'b1;
                if (r_j == w_j_last) begin
                    r_iss <= 1'b0;
                end else begin
                    r_j <= r_j + 1'b1;
                end
            end else begin
                r_pv <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_cmd_valid && i_cmd.op == REQ_RUN) begin
                        r_fin      <= '0;
                        r_total    <= '0;
                        r_progress <= 1'b0;
                        r_i        <= '0;
                        if (i_cfg.proc_n == '0) begin
                            r_state <= S_EMPTY;
                        end else if (i_cfg.res_m == '0) begin
                            r_state <= S_SCAN;
                        end else begin
                            r_j     <= '0;
                            r_iss   <= 1'b1;
                            r_state <= S_COPY;
                        end
                    end
                end
                S_COPY: begin
                    if (r_pv && r_plast) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (!r_fin[r_i] && i_cfg.res_m != '0) begin
                        r_j     <= '0;
                        r_iss   <= 1'b1;
                        r_fit   <= 1'b1;
                        r_state <= S_CHECK;
                    end
                end
                S_CHECK: begin
                    if (r_pv) begin
                        r_fit <= r_fit && !w_fail;
                    end
                    if (w_finish) begin
                        r_j     <= '0;
                        r_iss   <= 1'b1;
                        r_state <= S_ADD;
                    end
                end
                S_ADD: ;
                S_PEND: begin
                    r_k <= '0;
                    if (r_total == CW'(i_cfg.proc_n)) begin
                        r_state <= S_SAFE;
                    end else if (!r_progress) begin
                        r_state <= S_DEAD;
                    end else begin
                        r_i        <= '0;
                        r_progress <= 1'b0;
                        r_state    <= S_SCAN;
                    end
                end
                S_SAFE: begin
                    if (w_emit) begin
                        if (w_emit_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_DEAD: begin
                    if (!w_unfin[r_k]) begin
                        r_k <= r_k + 1'b1;
                    end else if (w_emit) begin
                        if (w_emit_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                S_EMPTY: begin
                    if (w_emit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_finish) begin
                r_fin[r_i] <= 1'b1;
                r_total    <= r_total + 1'b1;
                r_progress <= 1'b1;
            end

            if (w_next) begin
                if (r_i == w_i_last) begin
                    r_state <= S_PEND;
                end else begin
                    r_i     <= r_i + 1'b1;
                    r_state <= S_SCAN;
                end
            end
        end
    end

    a_total_matches_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_total) == $countones(r_fin))
        else $error("finish count out of step with finish marks");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv && r_plast |=> !r_pv)
        else $error("element sweep ran past its last element");

    a_marks_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_CHECK || r_state == S_ADD ||
         r_state == S_PEND || r_state == S_DEAD) |-> (r_fin & ~w_nmask) == '0)
        else $error("process beyond the count marked finished");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_emit && w_emit_last |=> r_state == S_IDLE)
        else $error("run kept going after its final result");

endmodule

// File: rtl/core/deadlock_detection_check_top.sv
// Deadlock detection engine. Load transactions write one element of the
// allocation matrix, the request matrix or the available vector; they drain at
// one per cycle through a short command queue while no run is in flight and
// produce no result. A run transaction copies available into a work vector and
// repeatedly sweeps the unfinished processes; it answers with the safe sequence
// (deadlocked = 0) or with the deadlocked processes in index order
// (deadlocked = 1), the final result flagged by last, or with one
// has_process = 0 result when the process count is zero. All stores sit in
// memories walked one element per cycle; loads behind a run wait in the queue
// until it ends.
// The matrices and the available vector are not cleared at reset: every
// element a run reads must have been loaded first. The user must write
// configuration only while no run is in flight; the block does not enforce it.
module deadlock_detection_check_top import dck_pkg::*; #(
    parameter int MAX_PROCESSES = DEF_MAX_PROCESSES,
    parameter int MAX_RESOURCES = DEF_MAX_RESOURCES,
    parameter int AMOUNT_BITS   = DEF_AMOUNT_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_req_type,
    input  logic [IDX_BITS-1:0]     i_process_index,
    input  logic [IDX_BITS-1:0]     i_resource_index,
    input  logic [AMT_IN_BITS-1:0]  i_amount,
    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic [PID_BITS-1:0]     o_process_id,
    output logic                    o_deadlocked,
    output logic                    o_has_process,
    output logic                    o_last,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    t_cmd w_push_cmd;
    t_cmd w_head_cmd;
    t_cfg w_cfg;
    logic w_push;
    logic w_full;
    logic w_head_valid;
    logic w_pop;

    dck_front #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_process_index  (i_process_index),
        .i_resource_index (i_resource_index),
        .i_amount         (i_amount),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_full           (w_full),
        .o_push           (w_push),
        .o_cmd            (w_push_cmd),
        .o_cfg            (w_cfg)
    );

    dck_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd)
    );

    dck_back #(
        .MAX_PROCESSES (MAX_PROCESSES),
        .MAX_RESOURCES (MAX_RESOURCES),
        .AMOUNT_BITS   (AMOUNT_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_cmd_valid   (w_head_valid),
        .i_cmd         (w_head_cmd),
        .o_cmd_pop     (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_process_id  (o_process_id),
        .o_deadlocked  (o_deadlocked),
        .o_has_process (o_has_process),
        .o_last        (o_last)
    );

endmodule

// File: tb/sv/deadlock_detection_check_top_tb.sv
module deadlock_detection_check_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dck_pkg::*;

    localparam int NPROC         = DEF_MAX_PROCESSES;
    localparam int NRES          = DEF_MAX_RESOURCES;
    localparam int SETTLE_CYCLES = 16;
    localparam int ITEM_TARGET   = 300;
    localparam int HOLD_CYCLES   = 400;
    localparam int HOLD_PHASE    = 3;
    localparam int SCRIPT_ROWS   = 22;

    typedef struct packed {
        logic [PID_BITS-1:0] pid;
        logic                deadlocked;
        logic                has_process;
        logic                last;
    } t_report;

    typedef struct packed {
        logic                   is_cfg;
        logic [CFG_BITS-1:0]    n_set;
        logic [CFG_BITS-1:0]    m_set;
        t_req                   op;
        logic [IDX_BITS-1:0]    p;
        logic [IDX_BITS-1:0]    r;
        logic [AMT_IN_BITS-1:0] amt;
        logic [1:0]             n_typed;
        t_report                exp_a;
        t_report                exp_b;
    } t_step;

    localparam t_report NONE          = '0;
    localparam t_report NO_PROCESS    = '{4'd0, 1'b0, 1'b0, 1'b1};
    localparam t_report P0_SAFE_LAST  = '{4'd0, 1'b0, 1'b1, 1'b1};
    localparam t_report P0_STUCK_LAST = '{4'd0, 1'b1, 1'b1, 1'b1};
    localparam t_report P1_SAFE       = '{4'd1, 1'b0, 1'b1, 1'b0};
    localparam t_report P1_STUCK_LAST = '{4'd1, 1'b1, 1'b1, 1'b1};

    // directed opening: single process, empty run, no resources, reordering, partial deadlock
    localparam t_step SCRIPT [SCRIPT_ROWS] = '{
        '{1'b0, 5'd0,  5'd0, REQ_ALLOC,   4'd0,  4'd0,  16'hFFFF, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_REQUEST, 4'd0,  4'd0,  16'hFFFF, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_AVAIL,   4'd0,  4'd0,  16'h0000, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_RUN,     4'd0,  4'd0,  16'h0000, 2'd1, P0_STUCK_LAST, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_AVAIL,   4'd0,  4'd0,  16'hFFFF, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_RUN,     4'd0,  4'd0,  16'h0000, 2'd1, P0_SAFE_LAST, NONE},
        '{1'b1, 5'd0,  5'd1, REQ_ALLOC,   4'd0,  4'd0,  16'h0000, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_RUN,     4'hF,  4'hF,  16'hFFFF, 2'd1, NO_PROCESS, NONE},
        // count beyond the engine size saturates, no resources means everyone fits
        '{1'b1, 5'd31, 5'd0, REQ_ALLOC,   4'd0,  4'd0,  16'h0000, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_RUN,     4'd5,  4'd10, 16'h5A5A, 2'd0, NONE, NONE},
        '{1'b1, 5'd2,  5'd1, REQ_ALLOC,   4'd0,  4'd0,  16'h0000, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_AVAIL,   4'd0,  4'd0,  16'h0001, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_REQUEST, 4'd1,  4'd0,  16'h0001, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_ALLOC,   4'd1,  4'd0,  16'hFFFF, 2'd0, NONE, NONE},
        // process 1 frees enough for process 0, work goes past 16 bits
        '{1'b0, 5'd0,  5'd0, REQ_RUN,     4'd0,  4'd0,  16'h0000, 2'd2, P1_SAFE, P0_SAFE_LAST},
        '{1'b0, 5'd0,  5'd0, REQ_AVAIL,   4'd0,  4'd0,  16'h0000, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_REQUEST, 4'd0,  4'd0,  16'h0000, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_ALLOC,   4'd0,  4'd0,  16'h0000, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_RUN,     4'd0,  4'd0,  16'h0000, 2'd1, P1_STUCK_LAST, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_ALLOC,   4'hF,  4'hF,  16'hFFFF, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_REQUEST, 4'hF,  4'hF,  16'hAAAA, 2'd0, NONE, NONE},
        '{1'b0, 5'd0,  5'd0, REQ_AVAIL,   4'hF,  4'hF,  16'h5555, 2'd0, NONE, NONE}
    };

    logic                    i_clk            = 1'b0;
    logic                    i_rst_n          = 1'b0;
    logic                    i_in_valid       = 1'b0;
    logic                    o_in_ready;
    logic [1:0]              i_req_type       = '0;
    logic [IDX_BITS-1:0]     i_process_index  = '0;
    logic [IDX_BITS-1:0]     i_resource_index = '0;
    logic [AMT_IN_BITS-1:0]  i_amount         = '0;
    logic                    o_out_valid;
    logic                    i_out_ready      = 1'b0;
    logic [PID_BITS-1:0]     o_process_id;
    logic                    o_deadlocked;
    logic                    o_has_process;
    logic                    o_last;
    logic                    i_cfg_we         = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_index      = '0;
    logic [CFG_BITS-1:0]     i_cfg_data       = '0;

    deadlock_detection_check_top dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_process_index  (i_process_index),
        .i_resource_index (i_resource_index),
        .i_amount         (i_amount),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_process_id     (o_process_id),
        .o_deadlocked     (o_deadlocked),
        .o_has_process    (o_has_process),
        .o_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // mirror of the block's stores and counts
    logic [CFG_BITS-1:0]    proc_cnt = CFG_RESET;
    logic [CFG_BITS-1:0]    res_cnt  = CFG_RESET;
    logic [AMT_IN_BITS-1:0] alloc_mx  [NPROC][NRES];
    logic [AMT_IN_BITS-1:0] need_mx   [NPROC][NRES];
    logic [AMT_IN_BITS-1:0] avail_vec [NRES];
    bit                     alloc_seen [NPROC][NRES];
    bit                     need_seen  [NPROC][NRES];
    bit                     avail_seen [NRES];

    t_report pending_reports [$];
    t_report fresh_reports [$];

    int items_sent, rand_items, reports_seen, mismatches;
    int runs_safe, runs_stuck, runs_empty;
    int hold_left;
    bit calm, rx_hold_req;

    function automatic void record_load(t_req op, logic [IDX_BITS-1:0] p,
                                        logic [IDX_BITS-1:0] r, logic [AMT_IN_BITS-1:0] amt);
        case (op)
            REQ_ALLOC: begin
                alloc_mx[p][r]   = amt;
                alloc_seen[p][r] = 1'b1;
            end
            REQ_REQUEST: begin
                need_mx[p][r]   = amt;
                need_seen[p][r] = 1'b1;
            end
            REQ_AVAIL: begin
                avail_vec[r]  = amt;
                avail_seen[r] = 1'b1;
            end
            default: ;
        endcase
    endfunction

    function automatic void predict_detection();
        int                  n, m, finished, last_stuck;
        logic [20:0]         work [NRES];
        bit                  done_mark [NPROC];
        logic [PID_BITS-1:0] order [NPROC];
        bit                  progress, fits;
        fresh_reports.delete();
        n = (proc_cnt > NPROC) ? NPROC : int'(proc_cnt);
        if (n > RESULT_LIMIT) n = RESULT_LIMIT;
        m = (res_cnt > NRES) ? NRES : int'(res_cnt);
        for (int j = 0; j < NRES; j++) work[j] = (j < m) ? 21'(avail_vec[j]) : '0;
        for (int i = 0; i < NPROC; i++) done_mark[i] = 1'b0;
        finished = 0;
        while (finished < n) begin
            progress = 1'b0;
            for (int i = 0; i < n; i++) begin
                if (done_mark[i]) continue;
                fits = 1'b1;
                for (int j = 0; j < m; j++)
                    if (21'(need_mx[i][j]) > work[j]) fits = 1'b0;
                if (fits) begin
                    for (int j = 0; j < m; j++) work[j] += 21'(alloc_mx[i][j]);
                    done_mark[i]    = 1'b1;
                    order[finished] = PID_BITS'(i);
                    finished++;
                    progress = 1'b1;
                end
            end
            if (!progress) break;
        end
        if (n == 0) begin
            fresh_reports.push_back(NO_PROCESS);
            runs_empty++;
        end else if (finished == n) begin
            for (int i = 0; i < n; i++)
                fresh_reports.push_back('{order[i], 1'b0, 1'b1, (i == n - 1)});
            runs_safe++;
        end else begin
            last_stuck = 0;
            for (int i = 0; i < n; i++) if (!done_mark[i]) last_stuck = i;
            for (int i = 0; i < n; i++)
                if (!done_mark[i])
                    fresh_reports.push_back('{PID_BITS'(i), 1'b1, 1'b1, (i == last_stuck)});
            runs_stuck++;
        end
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_count();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65) return CFG_BITS'($urandom_range(0, 4));
        if (roll < 90) return CFG_BITS'($urandom_range(5, 16));
        return CFG_BITS'($urandom_range(17, 31));
    endfunction

    // small amounts keep runs balanced between safe and deadlocked outcomes
    function automatic logic [AMT_IN_BITS-1:0] pick_amount();
        if ($urandom_range(0, 9) < 9) return AMT_IN_BITS'($urandom_range(0, 3));
        return AMT_IN_BITS'($urandom_range(0, 16'hFFFF));
    endfunction

    function automatic logic [IDX_BITS-1:0] pick_index(int limit);
        if (limit > 0) return IDX_BITS'($urandom_range(0, limit - 1));
        return IDX_BITS'($urandom_range(0, 15));
    endfunction

    task automatic send_item(t_req op, logic [IDX_BITS-1:0] p, logic [IDX_BITS-1:0] r,
                             logic [AMT_IN_BITS-1:0] amt, int n_typed = 0,
                             t_report exp_a = '0, t_report exp_b = '0);
        while (!calm && $urandom_range(0, 99) < 24) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_req_type       <= op;
        i_process_index  <= p;
        i_resource_index <= r;
        i_amount         <= amt;
        do @(posedge i_clk); while (!o_in_ready);
        items_sent++;
        if (op != REQ_RUN) begin
            record_load(op, p, r, amt);
        end else begin
            predict_detection();
            if (n_typed == 0) begin
                foreach (fresh_reports[k]) pending_reports.push_back(fresh_reports[k]);
            end else begin
                pending_reports.push_back(exp_a);
                if (n_typed > 1) pending_reports.push_back(exp_b);
            end
        end
    endtask

    // loads whatever a run at this size would read but was never written
    task automatic fill_region(int n, int m);
        for (int j = 0; j < m; j++)
            if (!avail_seen[j]) send_item(REQ_AVAIL, pick_index(0), IDX_BITS'(j), pick_amount());
        for (int i = 0; i < n; i++) begin
            for (int j = 0; j < m; j++) begin
                if (!alloc_seen[i][j])
                    send_item(REQ_ALLOC, IDX_BITS'(i), IDX_BITS'(j), pick_amount());
                if (!need_seen[i][j])
                    send_item(REQ_REQUEST, IDX_BITS'(i), IDX_BITS'(j), pick_amount());
            end
        end
    endtask

    task automatic drain(int settle);
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_counts(logic [CFG_BITS-1:0] n_val, logic [CFG_BITS-1:0] m_val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_PROCESS_COUNT;
        i_cfg_data  <= n_val;
        @(posedge i_clk);
        i_cfg_index <= REG_RESOURCE_COUNT;
        i_cfg_data  <= m_val;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        proc_cnt = n_val;
        res_cnt  = m_val;
    endtask

    // result side: check every transaction, random backpressure plus one long hold
    always @(posedge i_clk) begin
        t_report got, want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_process_id, o_deadlocked, o_has_process, o_last};
            reports_seen++;
            if (pending_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected report pid=%0d deadlocked=%0b has_process=%0b last=%0b",
                         $time, got.pid, got.deadlocked, got.has_process, got.last);
            end else begin
                want = pending_reports.pop_front();
                if (got !== want) begin
                    mismatches++;
                    $display("%0t: expected pid=%0d deadlocked=%0b has_process=%0b last=%0b",
                             $time, want.pid, want.deadlocked, want.has_process, want.last);
                    $display("%0t:   actual pid=%0d deadlocked=%0b has_process=%0b last=%0b",
                             $time, got.pid, got.deadlocked, got.has_process, got.last);
                end
            end
        end
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 24);
        end
    end

    initial begin
        int n_set, m_set, n_eff, m_eff, phase;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < SCRIPT_ROWS; k++) begin
            if (SCRIPT[k].is_cfg) begin
                drain(SETTLE_CYCLES);
                write_counts(SCRIPT[k].n_set, SCRIPT[k].m_set);
            end else begin
                send_item(SCRIPT[k].op, SCRIPT[k].p, SCRIPT[k].r, SCRIPT[k].amt,
                          int'(SCRIPT[k].n_typed), SCRIPT[k].exp_a, SCRIPT[k].exp_b);
            end
        end

        phase = 0;
        while (items_sent < ITEM_TARGET || phase < 6) begin
            phase++;
            case (phase)
                1:          begin n_set = NPROC; m_set = 2; end
                HOLD_PHASE: begin n_set = 8;     m_set = 2; end
                default: begin
                    // many processes only with few resources, keeps the load fill short
                    n_set = int'(pick_count());
                    m_set = (n_set > 4) ? int'($urandom_range(0, 4)) : int'(pick_count());
                end
            endcase
            drain(SETTLE_CYCLES);
            write_counts(CFG_BITS'(n_set), CFG_BITS'(m_set));
            calm = (phase == 5 || phase == 6);
            if (phase == HOLD_PHASE) rx_hold_req = 1'b1;
            n_eff = (n_set > NPROC) ? NPROC : n_set;
            m_eff = (m_set > NRES) ? NRES : m_set;
            repeat ((n_eff > 8) ? $urandom_range(1, 2) : $urandom_range(2, 6)) begin
                repeat ($urandom_range(0, 6)) begin
                    if ($urandom_range(0, 99) < 15)
                        send_item(t_req'($urandom_range(0, 2)), pick_index(0), pick_index(0),
                                  AMT_IN_BITS'($urandom_range(0, 16'hFFFF)));
                    else
                        send_item(t_req'($urandom_range(0, 2)), pick_index(n_eff),
                                  pick_index(m_eff), pick_amount());
                    rand_items++;
                end
                fill_region(n_eff, m_eff);
                send_item(REQ_RUN, pick_index(0), pick_index(0),
                          AMT_IN_BITS'($urandom_range(0, 16'hFFFF)));
                rand_items++;
                if (phase == 2 || $urandom_range(0, 99) < 20) drain(0);
            end
        end

        drain(50);
        $display("%0d transactions (%0d random) in %0d random phases, %0d reports checked",
                 items_sent, rand_items, phase, reports_seen);
        $display("detection runs: %0d safe, %0d deadlocked, %0d with no process",
                 runs_safe, runs_stuck, runs_empty);
        if (mismatches == 0 && pending_reports.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // this leaves room for hundreds of the largest runs
    initial begin
        #8_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
